@@ rtl/sdsh_pkg.sv @@
// Package: types, codes and constants for the SD card SPI host engine.
`default_nettype none
package sdsh_pkg;

   localparam int BLOCK_BYTES_DEF    = 512;
   localparam int RESPONSE_SLOTS_DEF = 8;
   localparam int WAKE_BYTES_DEF     = 10;

   localparam int BUF_AW = 9;
   localparam int CSR_AW = 4;

   // request codes
   localparam logic [2:0] REQ_SLOT  = 3'd0;
   localparam logic [2:0] REQ_INIT  = 3'd1;
   localparam logic [2:0] REQ_READ  = 3'd2;
   localparam logic [2:0] REQ_WRITE = 3'd3;
   localparam logic [2:0] REQ_LOAD  = 3'd4;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_IDLE  = 3'd1;
   localparam logic [2:0] ST_INIT_TO   = 3'd2;
   localparam logic [2:0] ST_CMD_REJ   = 3'd3;
   localparam logic [2:0] ST_TOKEN_TO  = 3'd4;
   localparam logic [2:0] ST_DATA_REJ  = 3'd5;
   localparam logic [2:0] ST_BUSY_TO   = 3'd6;
   localparam logic [2:0] ST_PROTECTED = 3'd7;

   // register byte addresses
   localparam logic [CSR_AW-1:0] ADDR_SDHC  = 4'h0;
   localparam logic [CSR_AW-1:0] ADDR_RETRY = 4'h4;
   localparam logic [CSR_AW-1:0] ADDR_TOKEN = 4'h8;
   localparam logic [CSR_AW-1:0] ADDR_BUSY  = 4'hC;

   // command codes
   localparam logic [5:0] CMD0  = 6'd0;
   localparam logic [5:0] CMD1  = 6'd1;
   localparam logic [5:0] CMD17 = 6'd17;
   localparam logic [5:0] CMD24 = 6'd24;

   localparam logic [7:0] CMD_START  = 8'h40;
   localparam logic [7:0] CRC_SD     = 8'h95;
   localparam logic [7:0] CRC_SDHC   = 8'h87;
   localparam logic [7:0] IDLE_BYTE  = 8'hFF;
   localparam logic [7:0] DATA_TOKEN = 8'hFE;
   localparam logic [3:0] DRESP_OK   = 4'h5;

   typedef enum logic [3:0] {
      PH_IDLE, PH_WAKE, PH_CMD, PH_RESP, PH_INIT_NEXT, PH_TOKEN,
      PH_RDATA, PH_RCRC, PH_WDATA, PH_WCRC, PH_WRESP, PH_BUSY
   } phase_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [31:0] block_address;
      logic [8:0]  buffer_index;
      logic [7:0]  buffer_byte;
      logic [7:0]  miso_byte;
      logic        write_protect;
   } req_type_s_type;

   typedef struct packed {
      logic [7:0] mosi_byte;
      logic       exchange_wanted;
      logic       select_n;
      logic [7:0] read_data;
      logic       read_valid;
      logic [8:0] read_position;
      logic       finished;
      logic [2:0] status;
      logic       fast_clock;
   } rsp_type;

endpackage
`default_nettype wire

@@ rtl/sdsh_if.sv @@
// Valid/ready channel interfaces for requests and results.
`default_nettype none
interface sdsh_req_if;
   logic                    valid;
   logic                    ready;
   sdsh_pkg::req_type_s_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface sdsh_rsp_if;
   logic              valid;
   logic              ready;
   sdsh_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ rtl/sd_card_spi_host_engine.sv @@
// Top level: SD card SPI-mode host engine, at most one byte exchange per item.
//
// Each accepted request item yields exactly one result item. An item is
// registered on acceptance, decoded against the sequencer state, and its
// result is placed in an output register; a one-entry skid register lets a
// new item enter while a result waits, so one item per cycle is sustained
// while the result side takes results, set by the single decode stage.
// The 512-byte write buffer is a memory with a registered read: the byte for
// the next data slot is prefetched while the previous one is sent. Reset
// needs no clearing pass.
`default_nettype none
module sd_card_spi_host_engine #(
   parameter int RESPONSE_SLOTS = sdsh_pkg::RESPONSE_SLOTS_DEF,
   parameter int WAKE_BYTES     = sdsh_pkg::WAKE_BYTES_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   sdsh_req_if.sink   req,
   sdsh_rsp_if.source rsp,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [sdsh_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [31:0]               csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);

   // configuration registers
   logic        sdhc_ff;
   logic [15:0] retry_lim_ff, token_lim_ff;
   logic [19:0] busy_lim_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         sdhc_ff      <= 1'b0;
         retry_lim_ff <= 16'd10000;
         token_lim_ff <= 16'd25000;
         busy_lim_ff  <= 20'd250000;
      end else if (csr_wr) begin
         unique case (csr_paddr)
            sdsh_pkg::ADDR_SDHC:  sdhc_ff      <= csr_pwdata[0];
            sdsh_pkg::ADDR_RETRY: retry_lim_ff <= csr_pwdata[15:0];
            sdsh_pkg::ADDR_TOKEN: token_lim_ff <= csr_pwdata[15:0];
            sdsh_pkg::ADDR_BUSY:  busy_lim_ff  <= csr_pwdata[19:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr)
         sdsh_pkg::ADDR_SDHC:  csr_prdata = {31'd0, sdhc_ff};
         sdsh_pkg::ADDR_RETRY: csr_prdata = {16'd0, retry_lim_ff};
         sdsh_pkg::ADDR_TOKEN: csr_prdata = {16'd0, token_lim_ff};
         sdsh_pkg::ADDR_BUSY:  csr_prdata = {12'd0, busy_lim_ff};
         default:              csr_prdata = 32'd0;
      endcase
   end

   // output register plus skid register
   sdsh_pkg::rsp_type out_ff, skid_ff, res;
   logic out_v_ff, skid_v_ff;

   // input stage
   sdsh_pkg::req_type_s_type in_ff;
   logic in_v_ff, stage_go;

   // stage advances when its result has somewhere to go
   assign stage_go = in_v_ff & ~skid_v_ff;
   assign req.ready = ~in_v_ff | ~skid_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (req.ready) begin
         in_v_ff <= req.valid;
      end
   end
   always_ff @(posedge clock) begin
      if (req.ready) begin
         in_ff <= req.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (~out_v_ff | rsp.ready) begin
            if (skid_v_ff) begin
               out_v_ff  <= 1'b1;
               skid_v_ff <= 1'b0;
            end else begin
               out_v_ff <= stage_go;
            end
         end else if (stage_go) begin
            skid_v_ff <= 1'b1;
         end
      end
   end
   always_ff @(posedge clock) begin
      if (~out_v_ff | rsp.ready) begin
         out_ff <= skid_v_ff ? skid_ff : res;
      end
      if (stage_go & out_v_ff & ~rsp.ready) begin
         skid_ff <= res;
      end
   end
   assign rsp.valid   = out_v_ff;
   assign rsp.payload = out_ff;

   // sequencer state
   sdsh_pkg::phase_type phase_ff, phase_in;
   logic [19:0] slot_ff, slot_in;
   logic [15:0] retry_ff, retry_in;
   logic [31:0] caddr_ff, caddr_in;
   logic [5:0]  cmd_ff, cmd_in;
   logic        fast_ff, fast_in;

   // write buffer, registered read with prefetch of the next data slot
   logic [7:0] wbuf [sdsh_pkg::BLOCK_BYTES_DEF];
   logic [7:0] rbyte_ff;
   logic [8:0] raddr;
   logic       ld_hit;

   always_ff @(posedge clock) begin
      if (stage_go && in_ff.req_type == sdsh_pkg::REQ_LOAD) begin
         wbuf[in_ff.buffer_index] <= in_ff.buffer_byte;
      end
      rbyte_ff <= wbuf[raddr];
   end

   // prefetch address: slot the sequencer will send next
   always_comb begin
      if (stage_go) begin
         raddr = slot_in[8:0];
      end else begin
         raddr = slot_ff[8:0];
      end
   end
   // a load in the same cycle as the prefetch is not yet in rbyte_ff
   logic       byp_v_ff;
   logic [8:0] byp_idx_ff;
   logic [7:0] byp_dat_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_v_ff <= 1'b0;
      end else begin
         byp_v_ff <= stage_go && in_ff.req_type == sdsh_pkg::REQ_LOAD;
      end
      byp_idx_ff <= in_ff.buffer_index;
      byp_dat_ff <= in_ff.buffer_byte;
   end
   assign ld_hit = byp_v_ff && byp_idx_ff == slot_ff[8:0];

   logic [7:0] wbyte;
   assign wbyte = ld_hit ? byp_dat_ff : rbyte_ff;

   // command byte k of the current frame
   function automatic logic [7:0] cmd_byte(input logic [2:0] k, input logic [5:0] c,
                                           input logic [31:0] a, input logic s);
      logic [7:0] b;
      unique case (k)
         3'd0:    b = sdsh_pkg::CMD_START | {2'b00, c};
         3'd1:    b = a[31:24];
         3'd2:    b = a[23:16];
         3'd3:    b = a[15:8];
         3'd4:    b = a[7:0];
         default: b = s ? sdsh_pkg::CRC_SDHC : sdsh_pkg::CRC_SD;
      endcase
      return b;
   endfunction

   localparam logic [19:0] WAKE_END  = 20'(1 + WAKE_BYTES);
   localparam logic [19:0] RESP_LAST = 20'(RESPONSE_SLOTS);

   logic [15:0] retry_eff, token_eff;
   logic [19:0] busy_eff;
   assign retry_eff = (retry_lim_ff == 16'd0) ? 16'd1 : retry_lim_ff;
   assign token_eff = (token_lim_ff == 16'd0) ? 16'd1 : token_lim_ff;
   assign busy_eff  = (busy_lim_ff == 20'd0) ? 20'd1 : busy_lim_ff;

   // decode one item
   always_comb begin
      logic [7:0] m;
      m = in_ff.miso_byte;
      phase_in = phase_ff;
      slot_in  = slot_ff;
      retry_in = retry_ff;
      caddr_in = caddr_ff;
      cmd_in   = cmd_ff;
      fast_in  = fast_ff;
      res = '0;
      res.select_n = 1'b1;

      // emit: exchange_wanted, byte, select
      unique case (in_ff.req_type)
         sdsh_pkg::REQ_SLOT: begin
            unique case (phase_ff)
               sdsh_pkg::PH_WAKE: begin
                  if (slot_ff < WAKE_END) begin
                     res.exchange_wanted = 1'b1; res.mosi_byte = sdsh_pkg::IDLE_BYTE;
                     slot_in = slot_ff + 20'd1;
                  end else begin
                     cmd_in = sdsh_pkg::CMD0; caddr_in = 32'd0;
                     res.exchange_wanted = 1'b1; res.select_n = 1'b0;
                     res.mosi_byte = sdsh_pkg::CMD_START;
                     phase_in = sdsh_pkg::PH_CMD; slot_in = 20'd1;
                  end
               end
               sdsh_pkg::PH_CMD: begin
                  res.exchange_wanted = 1'b1; res.select_n = 1'b0;
                  if (slot_ff < 20'd6) begin
                     res.mosi_byte = cmd_byte(slot_ff[2:0], cmd_ff, caddr_ff, sdhc_ff);
                     slot_in = slot_ff + 20'd1;
                  end else begin
                     res.mosi_byte = sdsh_pkg::IDLE_BYTE;
                     phase_in = sdsh_pkg::PH_RESP; slot_in = 20'd1;
                  end
               end
               sdsh_pkg::PH_RESP: begin
                  res.exchange_wanted = 1'b1; res.mosi_byte = sdsh_pkg::IDLE_BYTE;
                  if (m != sdsh_pkg::IDLE_BYTE || slot_ff >= RESP_LAST) begin
                     priority if (cmd_ff == sdsh_pkg::CMD0) begin
                        if (m != 8'd1) begin
                           res.finished = 1'b1; res.status = sdsh_pkg::ST_NOT_IDLE;
                           phase_in = sdsh_pkg::PH_IDLE;
                        end else begin
                           phase_in = sdsh_pkg::PH_INIT_NEXT;
                        end
                     end else if (cmd_ff == sdsh_pkg::CMD1) begin
                        if (m == 8'd0) begin
                           fast_in = 1'b1; res.finished = 1'b1;
                           res.status = sdsh_pkg::ST_OK; phase_in = sdsh_pkg::PH_IDLE;
                        end else if (retry_ff >= retry_eff) begin
                           res.finished = 1'b1; res.status = sdsh_pkg::ST_INIT_TO;
                           phase_in = sdsh_pkg::PH_IDLE;
                        end else begin
                           phase_in = sdsh_pkg::PH_INIT_NEXT;
                        end
                     end else if (m != 8'd0) begin
                        res.finished = 1'b1; res.status = sdsh_pkg::ST_CMD_REJ;
                        phase_in = sdsh_pkg::PH_IDLE;
                     end else if (cmd_ff == sdsh_pkg::CMD17) begin
                        res.select_n = 1'b0; phase_in = sdsh_pkg::PH_TOKEN;
                        slot_in = 20'd1;
                     end else begin
                        res.select_n = 1'b0; res.mosi_byte = sdsh_pkg::DATA_TOKEN;
                        phase_in = sdsh_pkg::PH_WDATA; slot_in = 20'd0;
                     end
                  end else begin
                     res.select_n = 1'b0; slot_in = slot_ff + 20'd1;
                  end
               end
               sdsh_pkg::PH_INIT_NEXT: begin
                  retry_in = retry_ff + 16'd1;
                  cmd_in = sdsh_pkg::CMD1; caddr_in = 32'd0;
                  res.exchange_wanted = 1'b1; res.select_n = 1'b0;
                  res.mosi_byte = sdsh_pkg::CMD_START | 8'd1;
                  phase_in = sdsh_pkg::PH_CMD; slot_in = 20'd1;
               end
               sdsh_pkg::PH_TOKEN: begin
                  res.exchange_wanted = 1'b1; res.mosi_byte = sdsh_pkg::IDLE_BYTE;
                  if (m == sdsh_pkg::DATA_TOKEN) begin
                     res.select_n = 1'b0; phase_in = sdsh_pkg::PH_RDATA; slot_in = 20'd0;
                  end else if (slot_ff >= {4'd0, token_eff}) begin
                     res.finished = 1'b1; res.status = sdsh_pkg::ST_TOKEN_TO;
                     phase_in = sdsh_pkg::PH_IDLE;
                  end else begin
                     res.select_n = 1'b0; slot_in = slot_ff + 20'd1;
                  end
               end
               sdsh_pkg::PH_RDATA: begin
                  res.read_data = m; res.read_valid = 1'b1;
                  res.read_position = slot_ff[8:0];
                  res.exchange_wanted = 1'b1; res.select_n = 1'b0;
                  res.mosi_byte = sdsh_pkg::IDLE_BYTE;
                  if (slot_ff < 20'd511) begin
                     slot_in = slot_ff + 20'd1;
                  end else begin
                     phase_in = sdsh_pkg::PH_RCRC; slot_in = 20'd1;
                  end
               end
               sdsh_pkg::PH_RCRC: begin
                  res.exchange_wanted = 1'b1; res.mosi_byte = sdsh_pkg::IDLE_BYTE;
                  if (slot_ff < 20'd2) begin
                     res.select_n = 1'b0; slot_in = slot_ff + 20'd1;
                  end else begin
                     res.finished = 1'b1; res.status = sdsh_pkg::ST_OK;
                     phase_in = sdsh_pkg::PH_IDLE;
                  end
               end
               sdsh_pkg::PH_WDATA: begin
                  res.exchange_wanted = 1'b1; res.select_n = 1'b0;
                  if (slot_ff < 20'd512) begin
                     res.mosi_byte = wbyte; slot_in = slot_ff + 20'd1;
                  end else begin
                     res.mosi_byte = sdsh_pkg::IDLE_BYTE;
                     phase_in = sdsh_pkg::PH_WCRC; slot_in = 20'd1;
                  end
               end
               sdsh_pkg::PH_WCRC: begin
                  res.exchange_wanted = 1'b1; res.select_n = 1'b0;
                  res.mosi_byte = sdsh_pkg::IDLE_BYTE;
                  if (slot_ff < 20'd2) slot_in = slot_ff + 20'd1;
                  else phase_in = sdsh_pkg::PH_WRESP;
               end
               sdsh_pkg::PH_WRESP: begin
                  res.exchange_wanted = 1'b1; res.mosi_byte = sdsh_pkg::IDLE_BYTE;
                  if (m[3:0] == sdsh_pkg::DRESP_OK) begin
                     res.select_n = 1'b0; phase_in = sdsh_pkg::PH_BUSY; slot_in = 20'd1;
                  end else begin
                     res.finished = 1'b1; res.status = sdsh_pkg::ST_DATA_REJ;
                     phase_in = sdsh_pkg::PH_IDLE;
                  end
               end
               sdsh_pkg::PH_BUSY: begin
                  res.exchange_wanted = 1'b1; res.mosi_byte = sdsh_pkg::IDLE_BYTE;
                  if (m != 8'd0) begin
                     res.finished = 1'b1; res.status = sdsh_pkg::ST_OK;
                     phase_in = sdsh_pkg::PH_IDLE;
                  end else if (slot_ff >= busy_eff) begin
                     res.finished = 1'b1; res.status = sdsh_pkg::ST_BUSY_TO;
                     phase_in = sdsh_pkg::PH_IDLE;
                  end else begin
                     res.select_n = 1'b0; slot_in = slot_ff + 20'd1;
                  end
               end
               default: ;
            endcase
         end
         sdsh_pkg::REQ_INIT: begin
            if (phase_ff == sdsh_pkg::PH_IDLE) begin
               fast_in = 1'b0; retry_in = 16'd0; caddr_in = 32'd0;
               res.exchange_wanted = 1'b1; res.mosi_byte = sdsh_pkg::IDLE_BYTE;
               slot_in = 20'd1; phase_in = sdsh_pkg::PH_WAKE;
            end
         end
         sdsh_pkg::REQ_READ, sdsh_pkg::REQ_WRITE: begin
            if (phase_ff == sdsh_pkg::PH_IDLE) begin
               if (in_ff.req_type == sdsh_pkg::REQ_WRITE && in_ff.write_protect) begin
                  res.finished = 1'b1; res.status = sdsh_pkg::ST_PROTECTED;
               end else begin
                  cmd_in = (in_ff.req_type == sdsh_pkg::REQ_READ) ?
                           sdsh_pkg::CMD17 : sdsh_pkg::CMD24;
                  caddr_in = {in_ff.block_address[22:0], 9'd0};
                  res.exchange_wanted = 1'b1; res.select_n = 1'b0;
                  res.mosi_byte = sdsh_pkg::CMD_START | {2'b00, cmd_in};
                  phase_in = sdsh_pkg::PH_CMD; slot_in = 20'd1;
               end
            end
         end
         default: ;
      endcase
      res.fast_clock = fast_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sdsh_pkg::PH_IDLE;
         slot_ff  <= 20'd0;
         retry_ff <= 16'd0;
         caddr_ff <= 32'd0;
         cmd_ff   <= sdsh_pkg::CMD0;
         fast_ff  <= 1'b0;
      end else if (stage_go) begin
         phase_ff <= phase_in;
         slot_ff  <= slot_in;
         retry_ff <= retry_in;
         caddr_ff <= caddr_in;
         cmd_ff   <= cmd_in;
         fast_ff  <= fast_in;
      end
   end

endmodule
`default_nettype wire

@@ test/tb.sv @@
// Testbench for the SD card SPI host engine: card emulation, prediction and result checking.
`timescale 1ns / 100ps
module tb;

   // Predicts each result of the engine and checks the results that come out
   class exchange_board;
      sdsh_pkg::rsp_type   expected_exchanges[$];
      int                  errors;
      sdsh_pkg::rsp_type   nx;
      // register copies
      bit          sdhc;
      bit [15:0]   retry_lim;
      bit [15:0]   token_lim;
      bit [19:0]   busy_lim;
      // sequencer copy
      sdsh_pkg::phase_type phase;
      bit [19:0]   slot;
      bit [15:0]   retry;
      bit [31:0]   cmd_addr;
      bit [5:0]    cmd;
      bit          fast;
      bit [7:0]    wbuf[512];

      function new();
         sdhc      = 0;
         retry_lim = 16'd10000;
         token_lim = 16'd25000;
         busy_lim  = 20'd250000;
         phase     = sdsh_pkg::PH_IDLE;
         slot      = 0;
         retry     = 0;
         cmd_addr  = 0;
         cmd       = sdsh_pkg::CMD0;
         fast      = 0;
         errors    = 0;
      endfunction

      function void set_reg(logic [sdsh_pkg::CSR_AW-1:0] a, logic [31:0] v);
         case (a)
            sdsh_pkg::ADDR_SDHC:  sdhc      = v[0];
            sdsh_pkg::ADDR_RETRY: retry_lim = v[15:0];
            sdsh_pkg::ADDR_TOKEN: token_lim = v[15:0];
            sdsh_pkg::ADDR_BUSY:  busy_lim  = v[19:0];
            default: ;
         endcase
      endfunction

      function void emit(bit [7:0] b, bit s);
         nx.mosi_byte       = b;
         nx.exchange_wanted = 1'b1;
         nx.select_n        = s;
      endfunction

      function void finish_seq(logic [2:0] st);
         nx.finished = 1'b1;
         nx.status   = st;
         phase       = sdsh_pkg::PH_IDLE;
      endfunction

      function void deselect_finish(logic [2:0] st);
         emit(sdsh_pkg::IDLE_BYTE, 1'b1);
         finish_seq(st);
      endfunction

      function bit [7:0] cmd_byte(bit [19:0] k);
         case (k)
            0: return sdsh_pkg::CMD_START | {2'b00, cmd};
            1: return cmd_addr[31:24];
            2: return cmd_addr[23:16];
            3: return cmd_addr[15:8];
            4: return cmd_addr[7:0];
            default: return sdhc ? sdsh_pkg::CRC_SDHC : sdsh_pkg::CRC_SD;
         endcase
      endfunction

      function void start_cmd(bit [5:0] c, bit [31:0] a);
         cmd      = c;
         cmd_addr = a;
         emit(cmd_byte(0), 1'b0);
         phase = sdsh_pkg::PH_CMD;
         slot  = 1;
      endfunction

      // card response to the current command
      function void resolve(bit [7:0] r);
         case (cmd)
            sdsh_pkg::CMD0:
               if (r != 8'd1) deselect_finish(sdsh_pkg::ST_NOT_IDLE);
               else begin
                  emit(sdsh_pkg::IDLE_BYTE, 1'b1);
                  phase = sdsh_pkg::PH_INIT_NEXT;
               end
            sdsh_pkg::CMD1:
               if (r == 8'd0) begin
                  fast = 1'b1;
                  deselect_finish(sdsh_pkg::ST_OK);
               end else if (retry >= retry_lim) begin
                  deselect_finish(sdsh_pkg::ST_INIT_TO);
               end else begin
                  emit(sdsh_pkg::IDLE_BYTE, 1'b1);
                  phase = sdsh_pkg::PH_INIT_NEXT;
               end
            sdsh_pkg::CMD17:
               if (r != 8'd0) deselect_finish(sdsh_pkg::ST_CMD_REJ);
               else begin
                  emit(sdsh_pkg::IDLE_BYTE, 1'b0);
                  phase = sdsh_pkg::PH_TOKEN;
                  slot  = 1;
               end
            default:
               if (r != 8'd0) deselect_finish(sdsh_pkg::ST_CMD_REJ);
               else begin
                  emit(sdsh_pkg::DATA_TOKEN, 1'b0);
                  phase = sdsh_pkg::PH_WDATA;
                  slot  = 0;
               end
         endcase
      endfunction

      function void byte_slot(bit [7:0] miso);
         case (phase)
            sdsh_pkg::PH_WAKE:
               if (slot < 1 + sdsh_pkg::WAKE_BYTES_DEF) begin
                  emit(sdsh_pkg::IDLE_BYTE, 1'b1);
                  slot++;
               end else start_cmd(sdsh_pkg::CMD0, 32'd0);
            sdsh_pkg::PH_CMD:
               if (slot < 6) begin
                  emit(cmd_byte(slot), 1'b0);
                  slot++;
               end else begin
                  emit(sdsh_pkg::IDLE_BYTE, 1'b0);
                  phase = sdsh_pkg::PH_RESP;
                  slot  = 1;
               end
            sdsh_pkg::PH_RESP:
               if (miso != sdsh_pkg::IDLE_BYTE || slot >= sdsh_pkg::RESPONSE_SLOTS_DEF)
                  resolve(miso);
               else begin
                  emit(sdsh_pkg::IDLE_BYTE, 1'b0);
                  slot++;
               end
            sdsh_pkg::PH_INIT_NEXT: begin
               retry++;
               start_cmd(sdsh_pkg::CMD1, 32'd0);
            end
            sdsh_pkg::PH_TOKEN:
               if (miso == sdsh_pkg::DATA_TOKEN) begin
                  emit(sdsh_pkg::IDLE_BYTE, 1'b0);
                  phase = sdsh_pkg::PH_RDATA;
                  slot  = 0;
               end else if (slot >= token_lim) begin
                  deselect_finish(sdsh_pkg::ST_TOKEN_TO);
               end else begin
                  emit(sdsh_pkg::IDLE_BYTE, 1'b0);
                  slot++;
               end
            sdsh_pkg::PH_RDATA: begin
               nx.read_data     = miso;
               nx.read_valid    = 1'b1;
               nx.read_position = slot[8:0];
               emit(sdsh_pkg::IDLE_BYTE, 1'b0);
               if (slot < sdsh_pkg::BLOCK_BYTES_DEF - 1) slot++;
               else begin
                  phase = sdsh_pkg::PH_RCRC;
                  slot  = 1;
               end
            end
            sdsh_pkg::PH_RCRC:
               if (slot < 2) begin
                  emit(sdsh_pkg::IDLE_BYTE, 1'b0);
                  slot++;
               end else deselect_finish(sdsh_pkg::ST_OK);
            sdsh_pkg::PH_WDATA:
               if (slot < sdsh_pkg::BLOCK_BYTES_DEF) begin
                  emit(wbuf[slot[8:0]], 1'b0);
                  slot++;
               end else begin
                  emit(sdsh_pkg::IDLE_BYTE, 1'b0);
                  phase = sdsh_pkg::PH_WCRC;
                  slot  = 1;
               end
            sdsh_pkg::PH_WCRC: begin
               emit(sdsh_pkg::IDLE_BYTE, 1'b0);
               if (slot < 2) slot++;
               else phase = sdsh_pkg::PH_WRESP;
            end
            sdsh_pkg::PH_WRESP:
               if (miso[3:0] == sdsh_pkg::DRESP_OK) begin
                  emit(sdsh_pkg::IDLE_BYTE, 1'b0);
                  phase = sdsh_pkg::PH_BUSY;
                  slot  = 1;
               end else deselect_finish(sdsh_pkg::ST_DATA_REJ);
            sdsh_pkg::PH_BUSY:
               if (miso != 8'd0) deselect_finish(sdsh_pkg::ST_OK);
               else if (slot >= busy_lim) deselect_finish(sdsh_pkg::ST_BUSY_TO);
               else begin
                  emit(sdsh_pkg::IDLE_BYTE, 1'b0);
                  slot++;
               end
            default: ;
         endcase
      endfunction

      // an accepted request item: advance the copy and queue its result
      function void note_request(sdsh_pkg::req_type_s_type r);
         nx          = '0;
         nx.select_n = 1'b1;
         case (r.req_type)
            sdsh_pkg::REQ_LOAD: wbuf[r.buffer_index] = r.buffer_byte;
            sdsh_pkg::REQ_SLOT: byte_slot(r.miso_byte);
            sdsh_pkg::REQ_INIT, sdsh_pkg::REQ_READ, sdsh_pkg::REQ_WRITE:
               if (phase == sdsh_pkg::PH_IDLE) begin
                  if (r.req_type == sdsh_pkg::REQ_INIT) begin
                     fast     = 0;
                     retry    = 0;
                     cmd_addr = 0;
                     emit(sdsh_pkg::IDLE_BYTE, 1'b1);
                     slot  = 1;
                     phase = sdsh_pkg::PH_WAKE;
                  end else if (r.req_type == sdsh_pkg::REQ_READ) begin
                     start_cmd(sdsh_pkg::CMD17, r.block_address << 9);
                  end else if (r.write_protect) begin
                     finish_seq(sdsh_pkg::ST_PROTECTED);
                  end else begin
                     start_cmd(sdsh_pkg::CMD24, r.block_address << 9);
                  end
               end
            default: ;
         endcase
         nx.fast_clock = fast;
         expected_exchanges.push_back(nx);
      endfunction

      function void check_result(sdsh_pkg::rsp_type a);
         sdsh_pkg::rsp_type e;
         if (expected_exchanges.size() == 0) begin
            $error("result item with nothing expected: %h", a);
            errors++;
            return;
         end
         e = expected_exchanges.pop_front();
         if (a.mosi_byte !== e.mosi_byte) begin
            $error("mosi_byte expected %h actual %h", e.mosi_byte, a.mosi_byte); errors++;
         end
         if (a.exchange_wanted !== e.exchange_wanted) begin
            $error("exchange_wanted expected %b actual %b", e.exchange_wanted,
                   a.exchange_wanted); errors++;
         end
         if (a.select_n !== e.select_n) begin
            $error("select_n expected %b actual %b", e.select_n, a.select_n); errors++;
         end
         if (a.read_data !== e.read_data) begin
            $error("read_data expected %h actual %h", e.read_data, a.read_data); errors++;
         end
         if (a.read_valid !== e.read_valid) begin
            $error("read_valid expected %b actual %b", e.read_valid, a.read_valid); errors++;
         end
         if (a.read_position !== e.read_position) begin
            $error("read_position expected %0d actual %0d", e.read_position,
                   a.read_position); errors++;
         end
         if (a.finished !== e.finished) begin
            $error("finished expected %b actual %b", e.finished, a.finished); errors++;
         end
         if (a.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, a.status); errors++;
         end
         if (a.fast_clock !== e.fast_clock) begin
            $error("fast_clock expected %b actual %b", e.fast_clock, a.fast_clock); errors++;
         end
      endfunction

      // card emulation: a plausible returned byte for the current phase
      function bit [7:0] pick_miso();
         case (phase)
            sdsh_pkg::PH_RESP: begin
               if ($urandom_range(0, 2) == 0) return sdsh_pkg::IDLE_BYTE;
               case (cmd)
                  sdsh_pkg::CMD0:
                     return ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'd1;
                  sdsh_pkg::CMD1:
                     return ($urandom_range(0, 2) == 0) ? 8'd0 : 8'd1;
                  default:
                     return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
               endcase
            end
            sdsh_pkg::PH_TOKEN:
               return ($urandom_range(0, 3) == 0) ? sdsh_pkg::DATA_TOKEN : 8'($urandom);
            sdsh_pkg::PH_WRESP:
               return ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                   : {4'($urandom), sdsh_pkg::DRESP_OK};
            sdsh_pkg::PH_BUSY: return ($urandom_range(0, 3) != 0) ? 8'd0 : 8'($urandom);
            default: return 8'($urandom);
         endcase
      endfunction
   endclass

   logic clock;
   logic reset;
   logic                          csr_psel, csr_penable, csr_pwrite;
   logic [sdsh_pkg::CSR_AW-1:0]   csr_paddr;
   logic [31:0]                   csr_pwdata;
   logic [31:0]                   csr_prdata;
   logic                          csr_pready;

   sdsh_req_if req_ch();
   sdsh_rsp_if rsp_ch();

   sd_card_spi_host_engine u_top (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   exchange_board board;
   bit            send_calm;
   bit            recv_calm;
   int            items_sent;

   // clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function int draw_gap(bit calm);
      if (calm) return 0;
      return $urandom_range(0, 14);
   endfunction

   // result side: random stalls per item
   initial begin
      int g;
      int cnt;
      rsp_ch.ready = 1'b0;
      cnt = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         g = draw_gap(recv_calm);
         if (g > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (g) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
         cnt++;
         if (cnt % 64 == 0) recv_calm = ($urandom_range(0, 3) == 0);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) board.check_result(rsp_ch.payload);
   end

   // one request item, called at a falling edge
   task automatic send_item(sdsh_pkg::req_type_s_type r);
      int g;
      g = draw_gap(send_calm);
      if (g > 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_ch.payload <= r;
      req_ch.valid   <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      board.note_request(r);
      items_sent++;
      @(negedge clock);
   endtask

   function sdsh_pkg::req_type_s_type rand_item(logic [2:0] kind);
      sdsh_pkg::req_type_s_type r;
      r.req_type      = kind;
      r.block_address = $urandom;
      r.buffer_index  = 9'($urandom);
      r.buffer_byte   = 8'($urandom);
      r.miso_byte     = 8'($urandom);
      r.write_protect = 1'($urandom);
      return r;
   endfunction

   task automatic send_slot();
      sdsh_pkg::req_type_s_type r;
      r = rand_item(sdsh_pkg::REQ_SLOT);
      r.miso_byte = board.pick_miso();
      send_item(r);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (board.expected_exchanges.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(logic [sdsh_pkg::CSR_AW-1:0] a, logic [31:0] v);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= a;
      csr_pwdata  <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_pready) board.set_reg(a, v);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // a new register setting, extremes favored
   task automatic reconfigure();
      logic [31:0] v;
      drain();
      csr_write(sdsh_pkg::ADDR_SDHC, 32'($urandom_range(0, 1)));
      case ($urandom_range(0, 4))
         0: v = 0;
         1: v = 1;
         2: v = 2;
         3: v = 65535;
         default: v = $urandom_range(1, 6);
      endcase
      csr_write(sdsh_pkg::ADDR_RETRY, v);
      case ($urandom_range(0, 3))
         0: v = 1;
         1: v = 65535;
         default: v = $urandom_range(1, 12);
      endcase
      csr_write(sdsh_pkg::ADDR_TOKEN, v);
      case ($urandom_range(0, 3))
         0: v = 1;
         1: v = 20'hFFFFF;
         default: v = $urandom_range(1, 12);
      endcase
      csr_write(sdsh_pkg::ADDR_BUSY, v);
   endtask

   // one sequence from its start until the engine is idle again
   task automatic run_sequence(logic [2:0] start_kind, bit hold);
      sdsh_pkg::req_type_s_type r;
      int n;
      r = rand_item(start_kind);
      case ($urandom_range(0, 7))
         0: r.block_address = 32'h0;
         1: r.block_address = 32'hFFFF_FFFF;
         default: ;
      endcase
      if (start_kind == sdsh_pkg::REQ_WRITE) r.write_protect = ($urandom_range(0, 7) == 0);
      send_item(r);
      n = 0;
      while (board.phase != sdsh_pkg::PH_IDLE) begin
         n++;
         if (hold && n == 5) drain();
         case ($urandom_range(0, 99))
            0, 1, 2: send_item(rand_item(sdsh_pkg::REQ_LOAD));
            3:       send_item(rand_item(3'($urandom_range(1, 3))));
            4:       send_item(rand_item(3'($urandom_range(5, 7))));
            default: send_slot();
         endcase
      end
   endtask

   // stimulus
   initial begin
      sdsh_pkg::req_type_s_type r;
      int seqs;
      int k;
      board       = new();
      items_sent  = 0;
      send_calm   = 0;
      recv_calm   = 0;
      reset       = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      csr_write(sdsh_pkg::ADDR_SDHC, 32'd1);
      csr_write(sdsh_pkg::ADDR_RETRY, 32'd2);
      csr_write(sdsh_pkg::ADDR_TOKEN, 32'd65535);
      csr_write(sdsh_pkg::ADDR_BUSY, 32'hFFFFF);

      // directed: idle slot, unused codes, protected write, buffer ends, busy starts
      r = rand_item(sdsh_pkg::REQ_SLOT);
      r.miso_byte = 8'hFF;
      send_item(r);
      for (k = 5; k <= 7; k++) send_item(rand_item(3'(k)));
      r = rand_item(sdsh_pkg::REQ_WRITE);
      r.write_protect = 1'b1;
      r.block_address = 32'hFFFF_FFFF;
      send_item(r);
      r = rand_item(sdsh_pkg::REQ_LOAD);
      r.buffer_index = 9'd0;
      r.buffer_byte  = 8'h00;
      send_item(r);
      r.buffer_index = 9'd511;
      r.buffer_byte  = 8'hFF;
      send_item(r);
      send_item(rand_item(sdsh_pkg::REQ_INIT));
      send_item(rand_item(sdsh_pkg::REQ_READ));
      send_item(rand_item(sdsh_pkg::REQ_INIT));
      r = rand_item(sdsh_pkg::REQ_WRITE);
      r.write_protect = 1'b0;
      send_item(r);
      while (board.phase != sdsh_pkg::PH_IDLE) send_slot();

      // fill the whole write buffer before any data phase can use it
      for (k = 0; k < sdsh_pkg::BLOCK_BYTES_DEF; k++) begin
         r = rand_item(sdsh_pkg::REQ_LOAD);
         r.buffer_index = 9'(k);
         send_item(r);
      end

      // random sequences with changing settings; the first one pauses mid-way
      seqs = 0;
      items_sent = 0;
      while (items_sent < 550) begin
         if (seqs % 4 == 0) reconfigure();
         send_calm = ($urandom_range(0, 3) == 0);
         if (seqs == 0) begin
            run_sequence(sdsh_pkg::REQ_READ, 1'b1);
         end else begin
            case ($urandom_range(0, 7))
               0, 1:    run_sequence(sdsh_pkg::REQ_INIT, 1'b0);
               2, 3, 4: run_sequence(sdsh_pkg::REQ_READ, 1'b0);
               default: run_sequence(sdsh_pkg::REQ_WRITE, 1'b0);
            endcase
         end
         seqs++;
      end

      req_ch.valid <= 1'b0;
      while (board.expected_exchanges.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (board.errors == 0) begin
         $display("sd_card_spi_host_engine regression: pass");
      end else begin
         $display("sd_card_spi_host_engine regression: fail");
      end
      $finish;
   end

   // run limit
   initial begin
      #20000000;
      $display("sd_card_spi_host_engine regression: fail");
      $finish;
   end
endmodule
